### design/kms_pkg.sv
// ----------------------------------------------------------------------------
// kms_pkg - key matrix scan shared types and constants
// Request/response payload structs, action codes and default matrix size.
// ----------------------------------------------------------------------------
package kms_pkg;

  localparam int DEF_NUM_COLS = 8;
  localparam int DEF_NUM_ROWS = 7;

  // Fixed field widths of the request and response payloads
  localparam int ACTION_W = 2;
  localparam int KEY_IDX_W = 3;
  localparam int COL_W = 8;
  localparam int ROW_W = 7;

  // Action codes; the unused code behaves as a plain scan
  localparam logic [ACTION_W-1:0] ACT_SCAN = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_PRESS = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0]  action;
    logic [KEY_IDX_W-1:0] key_col;
    logic [KEY_IDX_W-1:0] key_row;
    logic [COL_W-1:0]     col_drive;
    logic [ROW_W-1:0]     row_drive;
  } kms_req_t;

  typedef struct packed {
    logic [ROW_W-1:0] row_sense;
    logic [COL_W-1:0] col_sense;
  } kms_rsp_t;

endpackage

### design/key_matrix_scan_with_ghosting.sv
// ----------------------------------------------------------------------------
// key_matrix_scan_with_ghosting - keyboard matrix model with ghost keys
// Holds the pressed-key set and resolves sensed row/column lines per request.
// ----------------------------------------------------------------------------
// Each request first presses or releases one matrix point (out-of-range points
// and the spare action code change nothing), then resolves the sensed lines
// for the given active-low column and row drives, ghost keys included. A bit
// low in row_sense/col_sense means that line is pulled low; lines beyond the
// matrix size read high. The key store is cleared by reset. All work runs
// through one column-wide unit that visits one column per cycle (it holds on
// the last column of the final pass while the output register is full): a
// direct pass, then column-closure passes until nothing changes, then
// row-closure passes until nothing changes. Each closure runs at least one
// pass, and the row closure runs at least two once any column is pulled low.
// in_stall is high while a request is being resolved. The result sits in an
// output register, so the next request can be taken while the previous
// result still waits on out_stall.
module key_matrix_scan_with_ghosting #(
  parameter int NUM_COLS = kms_pkg::DEF_NUM_COLS,
  parameter int NUM_ROWS = kms_pkg::DEF_NUM_ROWS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  kms_pkg::kms_req_t in_req,
  output logic             out_valid,
  input  logic             out_stall,
  output kms_pkg::kms_rsp_t out_rsp
);
  import kms_pkg::*;

  localparam int CIW = $clog2(NUM_COLS);
  localparam logic [CIW-1:0] LAST_COL = CIW'(NUM_COLS - 1);

  // One-hot sequencer
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DIRECT = 4'b0010,
    S_COLCL  = 4'b0100,
    S_ROWCL  = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CIW-1:0]       col_idx_r, col_idx_nxt;
  logic [NUM_ROWS-1:0]  pk_r [NUM_COLS];     // pressed keys, one row mask per column
  logic [NUM_ROWS-1:0]  row_low_r, row_low_nxt;
  logic [NUM_COLS-1:0]  col_low_r, col_low_nxt;
  logic [NUM_ROWS-1:0]  touch_r, touch_nxt;  // rows reached by pulled-low columns
  logic                 chg_r, chg_nxt;      // something changed during this pass
  logic [NUM_COLS-1:0]  col_drv_r, col_drv_nxt;
  logic [NUM_ROWS-1:0]  row_drv_r, row_drv_nxt;
  logic                 out_valid_r, out_valid_nxt;
  kms_rsp_t             out_rsp_r, out_rsp_nxt;

  logic [NUM_COLS-1:0]  col_drv_ext;
  logic [NUM_ROWS-1:0]  row_drv_ext;
  logic [NUM_ROWS-1:0]  pk_sel;
  logic [NUM_COLS-1:0]  col_bit;
  logic                 in_acc;
  logic                 out_free;
  logic                 key_ok;
  logic [CIW-1:0]       key_idx;
  logic [NUM_ROWS-1:0]  key_mask;
  kms_rsp_t             rsp_calc;

  // Drives widened to the matrix size; absent drive bits count as driven low
  for (genvar g = 0; g < NUM_COLS; g++) begin : g_cdrv
    if (g < COL_W) begin : g_in
      assign col_drv_ext[g] = in_req.col_drive[g];
    end else begin : g_pad
      assign col_drv_ext[g] = 1'b0;
    end
  end
  for (genvar g = 0; g < NUM_ROWS; g++) begin : g_rdrv
    if (g < ROW_W) begin : g_in
      assign row_drv_ext[g] = in_req.row_drive[g];
    end else begin : g_pad
      assign row_drv_ext[g] = 1'b0;
    end
  end

  // Sensed lines: inverted pull-low sets, missing lines read high
  for (genvar g = 0; g < COL_W; g++) begin : g_csense
    if (g < NUM_COLS) begin : g_in
      assign rsp_calc.col_sense[g] = ~col_low_nxt[g];
    end else begin : g_pad
      assign rsp_calc.col_sense[g] = 1'b1;
    end
  end
  for (genvar g = 0; g < ROW_W; g++) begin : g_rsense
    if (g < NUM_ROWS) begin : g_in
      assign rsp_calc.row_sense[g] = ~row_low_nxt[g];
    end else begin : g_pad
      assign rsp_calc.row_sense[g] = 1'b1;
    end
  end

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign key_ok   = (in_req.action == ACT_PRESS || in_req.action == ACT_RELEASE) &&
                    (int'(in_req.key_col) < NUM_COLS) &&
                    (int'(in_req.key_row) < NUM_ROWS);
  assign key_idx  = CIW'(in_req.key_col);
  assign key_mask = NUM_ROWS'(1) << in_req.key_row;

  // Shared column unit operand
  assign pk_sel  = pk_r[col_idx_r];
  assign col_bit = NUM_COLS'(1) << col_idx_r;

  always_comb begin
    state_nxt     = state_r;
    col_idx_nxt   = col_idx_r;
    row_low_nxt   = row_low_r;
    col_low_nxt   = col_low_r;
    touch_nxt     = touch_r;
    chg_nxt       = chg_r;
    col_drv_nxt   = col_drv_r;
    row_drv_nxt   = row_drv_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_rsp_nxt   = out_rsp_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          col_drv_nxt = col_drv_ext;
          row_drv_nxt = row_drv_ext;
          col_idx_nxt = '0;
          row_low_nxt = '0;
          col_low_nxt = '0;
          state_nxt   = S_DIRECT;
        end
      end
      S_DIRECT: begin
        // Driven column pulls its keyed rows; a column keyed on a driven row is pulled
        if (!col_drv_r[col_idx_r]) begin
          row_low_nxt = row_low_r | pk_sel;
        end
        if (|(pk_sel & ~row_drv_r)) begin
          col_low_nxt = col_low_r | col_bit;
        end
        if (col_idx_r == LAST_COL) begin
          col_idx_nxt = '0;
          chg_nxt     = 1'b0;
          state_nxt   = S_COLCL;
        end else begin
          col_idx_nxt = col_idx_r + 1'b1;
        end
      end
      S_COLCL: begin
        if (|(row_low_r & pk_sel)) begin
          row_low_nxt = row_low_r | pk_sel;
          col_low_nxt = col_low_r | col_bit;
        end
        chg_nxt = chg_r || (row_low_nxt != row_low_r) || (col_low_nxt != col_low_r);
        if (col_idx_r == LAST_COL) begin
          col_idx_nxt = '0;
          if (chg_nxt) begin
            chg_nxt = 1'b0;
          end else begin
            touch_nxt = '0;
            state_nxt = S_ROWCL;
          end
        end else begin
          col_idx_nxt = col_idx_r + 1'b1;
        end
      end
      S_ROWCL: begin
        // A pulled-low column spreads to every column sharing a keyed row
        if (col_low_r[col_idx_r] || |(pk_sel & touch_r)) begin
          col_low_nxt = col_low_r | col_bit;
          touch_nxt   = touch_r | pk_sel;
          row_low_nxt = row_low_r | pk_sel;
        end
        chg_nxt = chg_r || (col_low_nxt != col_low_r) || (touch_nxt != touch_r);
        if (col_idx_r == LAST_COL) begin
          if (chg_nxt) begin
            col_idx_nxt = '0;
            chg_nxt     = 1'b0;
          end else if (out_free) begin
            out_valid_nxt = 1'b1;
            out_rsp_nxt   = rsp_calc;
            col_idx_nxt   = '0;
            state_nxt     = S_IDLE;
          end
          // else: stable, hold on the last column until the output slot frees
        end else begin
          col_idx_nxt = col_idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_idx_r   <= '0;
      chg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_idx_r   <= col_idx_nxt;
      chg_r       <= chg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_low_r <= row_low_nxt;
    col_low_r <= col_low_nxt;
    touch_r   <= touch_nxt;
    col_drv_r <= col_drv_nxt;
    row_drv_r <= row_drv_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  // Key store, updated as a request is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COLS; i++) begin
        pk_r[i] <= '0;
      end
    end else if (in_acc && key_ok) begin
      if (in_req.action == ACT_PRESS) begin
        pk_r[key_idx] <= pk_r[key_idx] | key_mask;
      end else begin
        pk_r[key_idx] <= pk_r[key_idx] & ~key_mask;
      end
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule
